[hw/rtl/arpc_pkg.sv]
// Shared constants, codes and control types of the ARP receive checker and neighbor cache.
`default_nettype none
package arpc_pkg;

   localparam int CACHE_ENTRIES = 8;
   localparam int SLOT_W        = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
   localparam int CNT_W         = $clog2(CACHE_ENTRIES + 1);

   localparam int IP_W       = 32;
   localparam int MAC_W      = 48;
   localparam int TICK_W     = 32;
   localparam int SLOT_OUT_W = 3;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 48;

   localparam int REQ_TDATA_W = 224;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 136;
   localparam int RSP_TUSER_W = 3;
   localparam int RSP_PAD_W   = RSP_TDATA_W - (2 * MAC_W + IP_W + SLOT_OUT_W);

   localparam logic [15:0]       ARP_MIN_LEN    = 16'd28;
   localparam logic [15:0]       HW_ETHER       = 16'd1;
   localparam logic [15:0]       PROTO_IPV4     = 16'h0800;
   localparam logic [7:0]        HW_ADDR_LEN    = 8'd6;
   localparam logic [7:0]        PROTO_ADDR_LEN = 8'd4;
   localparam logic [15:0]       OP_REQUEST     = 16'd1;
   localparam logic [TICK_W-1:0] TIMEOUT_RESET  = 32'd30000;

   typedef enum logic [1:0] {
      FUNC_LOOKUP,
      FUNC_UPDATE,
      FUNC_FLUSH,
      FUNC_PACKET
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_MISS,
      STATUS_SHORT,
      STATUS_BAD_FORMAT
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OWN_IP,
      CSR_OWN_MAC,
      CSR_TIMEOUT
   } csr_index_type;

   typedef enum logic [2:0] {
      CTRL_IDLE,
      CTRL_DECODE,
      CTRL_SCAN,
      CTRL_WRITE,
      CTRL_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic load_req;
      logic start_scan;
      logic scan_step;
      logic write_entry;
      logic clear_all;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      func_type func;
      logic     pkt_good;
      logic     scan_done;
      logic     out_free;
   } dp_status_type;

endpackage
`default_nettype wire

[hw/rtl/arp_receive_and_cache.sv]
// Top level of the ARP receive checker with an ageing neighbor cache.
// One word at a time: accept, a decode state, a scan of one slot per cycle through a registered
// read and a check stage, a write state for update or learn, and a done state that loads the result.
// A hit ends the scan early; a lookup skips the write; flush and rejected packets skip scan and write.
// Synchronous active-high reset clears all valid bits at once and resets the configuration and control registers.
`default_nettype none
module arp_receive_and_cache (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_we,
   input  wire  [arpc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [arpc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // now, addr_ip, addr_mac, pkt_target_ip, pkt_hw_type, pkt_proto_type,
   // pkt_hw_len, pkt_proto_len, pkt_opcode, pkt_len
   input  wire  [arpc_pkg::REQ_TDATA_W-1:0] req_tdata,
   // func
   input  wire  [arpc_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // found_mac, slot, reply_ip, reply_mac, zero fill
   output logic [arpc_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // status, send_reply
   output logic [arpc_pkg::RSP_TUSER_W-1:0] rsp_tuser
);

   arpc_pkg::ctrl_cmd_type  cmd;
   arpc_pkg::dp_status_type status;

   arpc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   arpc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

[hw/rtl/arpc_ctrl.sv]
// Controller state machine that sequences decode, cache scan, entry write and result load.
`default_nettype none
module arpc_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  arpc_pkg::dp_status_type status,
   output arpc_pkg::ctrl_cmd_type  cmd
);

   arpc_pkg::ctrl_state_type state_ff;
   arpc_pkg::ctrl_state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         arpc_pkg::CTRL_IDLE: begin
            if (req_tvalid) begin
               state_in = arpc_pkg::CTRL_DECODE;
            end
         end
         arpc_pkg::CTRL_DECODE: begin
            unique case (status.func) inside
               arpc_pkg::FUNC_LOOKUP, arpc_pkg::FUNC_UPDATE: begin
                  state_in = arpc_pkg::CTRL_SCAN;
               end
               arpc_pkg::FUNC_PACKET: begin
                  state_in = status.pkt_good ? arpc_pkg::CTRL_SCAN : arpc_pkg::CTRL_DONE;
               end
               default: begin
                  state_in = arpc_pkg::CTRL_DONE;
               end
            endcase
         end
         arpc_pkg::CTRL_SCAN: begin
            if (status.scan_done) begin
               state_in = (status.func == arpc_pkg::FUNC_LOOKUP) ? arpc_pkg::CTRL_DONE
                                                                : arpc_pkg::CTRL_WRITE;
            end
         end
         arpc_pkg::CTRL_WRITE: begin
            state_in = arpc_pkg::CTRL_DONE;
         end
         arpc_pkg::CTRL_DONE: begin
            if (status.out_free) begin
               state_in = arpc_pkg::CTRL_IDLE;
            end
         end
         default: begin
            state_in = arpc_pkg::CTRL_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         arpc_pkg::CTRL_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_req = req_tvalid;
         end
         arpc_pkg::CTRL_DECODE: begin
            cmd.start_scan = 1'b1;
            cmd.clear_all  = (status.func == arpc_pkg::FUNC_FLUSH);
         end
         arpc_pkg::CTRL_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         arpc_pkg::CTRL_WRITE: begin
            cmd.write_entry = 1'b1;
         end
         arpc_pkg::CTRL_DONE: begin
            cmd.load_rsp = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= arpc_pkg::CTRL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/arpc_datapath.sv]
// Datapath with configuration registers, word capture, cache memory, ageing scan and result register.
`default_nettype none
module arpc_datapath (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  csr_we,
   input  wire  [arpc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [arpc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  wire  [arpc_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  wire  [arpc_pkg::REQ_TUSER_W-1:0]     req_tuser,
   input  arpc_pkg::ctrl_cmd_type               cmd,
   output arpc_pkg::dp_status_type              status,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [arpc_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic [arpc_pkg::RSP_TUSER_W-1:0]     rsp_tuser
);

   localparam int N       = arpc_pkg::CACHE_ENTRIES;
   localparam int SLOT_W  = arpc_pkg::SLOT_W;
   localparam int CNT_W   = arpc_pkg::CNT_W;
   localparam int IP_W    = arpc_pkg::IP_W;
   localparam int MAC_W   = arpc_pkg::MAC_W;
   localparam int TICK_W  = arpc_pkg::TICK_W;

   // Configuration.
   logic [IP_W-1:0]   own_ip_ff, own_ip_in;
   logic [TICK_W-1:0] timeout_ff, timeout_in;

   // Captured word.
   arpc_pkg::func_type func_ff;
   logic [TICK_W-1:0] now_ff;
   logic [IP_W-1:0]   ip_ff;
   logic [MAC_W-1:0]  mac_ff;
   logic [IP_W-1:0]   tgt_ip_ff;
   logic [15:0]       hw_type_ff;
   logic [15:0]       proto_type_ff;
   logic [7:0]        hw_len_ff;
   logic [7:0]        proto_len_ff;
   logic [15:0]       opcode_ff;
   logic [15:0]       pkt_len_ff;

   // Cache store.
   logic [N-1:0]      valid_ff, valid_in;
   logic [IP_W-1:0]   entry_ip_ff      [N];
   logic [MAC_W-1:0]  entry_mac_ff     [N];
   logic [TICK_W-1:0] entry_created_ff [N];

   // Scan pipeline.
   logic [CNT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              chk_vld_ff, chk_vld_in;
   logic [SLOT_W-1:0] chk_idx_ff;
   logic [IP_W-1:0]   rd_ip_ff;
   logic [MAC_W-1:0]  rd_mac_ff;
   logic [TICK_W-1:0] rd_created_ff;
   logic              free_found_ff, free_found_in;
   logic [SLOT_W-1:0] free_idx_ff, free_idx_in;
   logic [SLOT_W-1:0] tgt_idx_ff, tgt_idx_in;
   logic              hit_ff, hit_in;
   logic [MAC_W-1:0]  found_mac_ff;

   logic              rd_in_range;
   logic [TICK_W-1:0] age;
   logic              chk_live;
   logic              chk_stale;
   logic              chk_hit;
   logic              chk_free;
   logic              chk_last;

   // Packet checks.
   logic              pkt_short;
   logic              pkt_bad_format;
   logic              pkt_good;
   logic              want_reply;

   // Result register.
   logic                               rsp_tvalid_ff, rsp_tvalid_in;
   logic                               out_free;
   arpc_pkg::status_type               res_status;
   logic [MAC_W-1:0]                   res_found_mac;
   logic [arpc_pkg::SLOT_OUT_W-1:0]    res_slot;
   logic                               res_reply;
   logic [IP_W-1:0]                    res_reply_ip;
   logic [MAC_W-1:0]                   res_reply_mac;
   arpc_pkg::status_type               rsp_status_ff;
   logic [MAC_W-1:0]                   rsp_found_mac_ff;
   logic [arpc_pkg::SLOT_OUT_W-1:0]    rsp_slot_ff;
   logic                               rsp_reply_ff;
   logic [IP_W-1:0]                    rsp_reply_ip_ff;
   logic [MAC_W-1:0]                   rsp_reply_mac_ff;

   always_comb begin
      own_ip_in  = own_ip_ff;
      timeout_in = timeout_ff;
      if (csr_we) begin
         unique case (csr_index)
            arpc_pkg::CSR_OWN_IP: begin
               own_ip_in = csr_wdata[IP_W-1:0];
            end
            arpc_pkg::CSR_TIMEOUT: begin
               timeout_in = csr_wdata[TICK_W-1:0];
            end
            default: begin
               // The own MAC feeds no result field and is not held.
               own_ip_in = own_ip_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff       <= arpc_pkg::func_type'(req_tuser);
         now_ff        <= req_tdata[31:0];
         ip_ff         <= req_tdata[63:32];
         mac_ff        <= req_tdata[111:64];
         tgt_ip_ff     <= req_tdata[143:112];
         hw_type_ff    <= req_tdata[159:144];
         proto_type_ff <= req_tdata[175:160];
         hw_len_ff     <= req_tdata[183:176];
         proto_len_ff  <= req_tdata[191:184];
         opcode_ff     <= req_tdata[207:192];
         pkt_len_ff    <= req_tdata[223:208];
      end
   end

   assign pkt_short      = (pkt_len_ff < arpc_pkg::ARP_MIN_LEN);
   assign pkt_bad_format = (hw_type_ff != arpc_pkg::HW_ETHER) ||
                           (proto_type_ff != arpc_pkg::PROTO_IPV4) ||
                           (hw_len_ff != arpc_pkg::HW_ADDR_LEN) ||
                           (proto_len_ff != arpc_pkg::PROTO_ADDR_LEN);
   assign pkt_good       = !pkt_short && !pkt_bad_format;
   assign want_reply     = (opcode_ff == arpc_pkg::OP_REQUEST) && (tgt_ip_ff == own_ip_ff);

   assign rd_in_range = (rd_idx_ff < CNT_W'(N));
   assign age         = now_ff - rd_created_ff;
   assign chk_live    = valid_ff[chk_idx_ff];
   assign chk_stale   = chk_vld_ff && chk_live && (age > timeout_ff);
   assign chk_hit     = chk_vld_ff && chk_live && !chk_stale && (rd_ip_ff == ip_ff);
   assign chk_free    = chk_vld_ff && (!chk_live || chk_stale);
   assign chk_last    = chk_vld_ff && (chk_idx_ff == SLOT_W'(N - 1));

   always_comb begin
      rd_idx_in     = rd_idx_ff;
      chk_vld_in    = chk_vld_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      tgt_idx_in    = tgt_idx_ff;
      hit_in        = hit_ff;
      valid_in      = valid_ff;
      if (cmd.start_scan) begin
         rd_idx_in     = '0;
         chk_vld_in    = 1'b0;
         free_found_in = 1'b0;
         hit_in        = 1'b0;
      end
      if (cmd.scan_step) begin
         chk_vld_in = rd_in_range;
         if (rd_in_range) begin
            rd_idx_in = rd_idx_ff + CNT_W'(1);
         end
         if (chk_stale) begin
            valid_in[chk_idx_ff] = 1'b0;
         end
         if (chk_free && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = chk_idx_ff;
         end
         if (chk_hit) begin
            hit_in     = 1'b1;
            tgt_idx_in = chk_idx_ff;
         end else if (chk_last) begin
            if (free_found_ff) begin
               tgt_idx_in = free_idx_ff;
            end else if (chk_free) begin
               tgt_idx_in = chk_idx_ff;
            end else begin
               tgt_idx_in = '0;
            end
         end
      end
      if (cmd.write_entry) begin
         valid_in[tgt_idx_ff] = 1'b1;
      end
      if (cmd.clear_all) begin
         valid_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_entry) begin
         entry_ip_ff[tgt_idx_ff]      <= ip_ff;
         entry_mac_ff[tgt_idx_ff]     <= mac_ff;
         entry_created_ff[tgt_idx_ff] <= now_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_step && rd_in_range) begin
         rd_ip_ff      <= entry_ip_ff[rd_idx_ff[SLOT_W-1:0]];
         rd_mac_ff     <= entry_mac_ff[rd_idx_ff[SLOT_W-1:0]];
         rd_created_ff <= entry_created_ff[rd_idx_ff[SLOT_W-1:0]];
         chk_idx_ff    <= rd_idx_ff[SLOT_W-1:0];
      end
      if (cmd.scan_step && chk_hit) begin
         found_mac_ff <= rd_mac_ff;
      end
      free_idx_ff <= free_idx_in;
      tgt_idx_ff  <= tgt_idx_in;
   end

   assign out_free      = !rsp_tvalid_ff || rsp_tready;
   assign rsp_tvalid_in = (rsp_tvalid_ff && !rsp_tready) || cmd.load_rsp;

   always_comb begin
      res_status    = arpc_pkg::STATUS_OK;
      res_found_mac = '0;
      res_slot      = '0;
      res_reply     = 1'b0;
      res_reply_ip  = '0;
      res_reply_mac = '0;
      unique case (func_ff)
         arpc_pkg::FUNC_LOOKUP: begin
            if (hit_ff) begin
               res_found_mac = found_mac_ff;
               res_slot      = arpc_pkg::SLOT_OUT_W'(tgt_idx_ff);
            end else begin
               res_status = arpc_pkg::STATUS_MISS;
            end
         end
         arpc_pkg::FUNC_UPDATE: begin
            res_slot = arpc_pkg::SLOT_OUT_W'(tgt_idx_ff);
         end
         arpc_pkg::FUNC_PACKET: begin
            if (pkt_short) begin
               res_status = arpc_pkg::STATUS_SHORT;
            end else if (pkt_bad_format) begin
               res_status = arpc_pkg::STATUS_BAD_FORMAT;
            end else begin
               res_slot = arpc_pkg::SLOT_OUT_W'(tgt_idx_ff);
               if (want_reply) begin
                  res_reply     = 1'b1;
                  res_reply_ip  = ip_ff;
                  res_reply_mac = mac_ff;
               end
            end
         end
         default: begin
            res_status = arpc_pkg::STATUS_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff    <= res_status;
         rsp_found_mac_ff <= res_found_mac;
         rsp_slot_ff      <= res_slot;
         rsp_reply_ff     <= res_reply;
         rsp_reply_ip_ff  <= res_reply_ip;
         rsp_reply_mac_ff <= res_reply_mac;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff     <= '0;
         timeout_ff    <= arpc_pkg::TIMEOUT_RESET;
         valid_ff      <= '0;
         rd_idx_ff     <= '0;
         chk_vld_ff    <= 1'b0;
         free_found_ff <= 1'b0;
         hit_ff        <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         own_ip_ff     <= own_ip_in;
         timeout_ff    <= timeout_in;
         valid_ff      <= valid_in;
         rd_idx_ff     <= rd_idx_in;
         chk_vld_ff    <= chk_vld_in;
         free_found_ff <= free_found_in;
         hit_ff        <= hit_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign status.func      = func_ff;
   assign status.pkt_good  = pkt_good;
   assign status.scan_done = chk_hit || chk_last;
   assign status.out_free  = out_free;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{arpc_pkg::RSP_PAD_W{1'b0}}, rsp_reply_mac_ff, rsp_reply_ip_ff,
                        rsp_slot_ff, rsp_found_mac_ff};
   assign rsp_tuser  = {rsp_reply_ff, rsp_status_ff};

`ifndef SYNTH
   a_write_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.write_entry |=> valid_ff[$past(tgt_idx_ff)])
      else $error("Written cache entry is not marked valid.");

   a_flush_clears_all: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_all |=> (valid_ff == '0))
      else $error("Flush left a valid cache entry.");

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_tvalid_ff || rsp_tready))
      else $error("Result loaded over a word that was not taken.");

   a_check_in_range: assert property (@(posedge clock) disable iff (reset)
      chk_vld_ff |-> (chk_idx_ff <= SLOT_W'(N - 1)))
      else $error("Scan checks a slot beyond the cache.");

   a_hit_recorded: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_step && chk_hit) |=> (hit_ff && (tgt_idx_ff == $past(chk_idx_ff))))
      else $error("Scan hit was not recorded.");
`endif

endmodule
`default_nettype wire
